FILE: rtl/core/msa_pkg.sv
// shared types and constants for the moving average smoother
`default_nettype none
package msa_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int WIN_W          = 7;
  localparam int HELD_W         = 7;
  localparam int DEF_MAX_WINDOW = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/msa_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module msa_div #(
  parameter int DIVIDEND_W = 18
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [DIVIDEND_W-1:0]              dividend,
  input  wire logic [msa_pkg::HELD_W-1:0]         divisor,
  output logic                                    busy,
  output logic [DIVIDEND_W-1:0]                   quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);
  localparam int D_W   = msa_pkg::HELD_W;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [D_W-1:0]        rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [D_W:0]          rem_shift;
  logic                  take;

  assign rem_shift = {rem_r, quo_r[DIVIDEND_W-1]};
  assign take      = (rem_shift >= {1'b0, divisor});

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      cnt_nxt = CNT_W'(DIVIDEND_W);
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      // remainder stays below the divisor, so it fits back in D_W bits
      rem_nxt = take ? D_W'(rem_shift - {1'b0, divisor}) : rem_shift[D_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: rtl/core/msa_ctrl.sv
// sequencing state machine for the smoother
`default_nettype none
module msa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire msa_pkg::sts_t sts,
  output msa_pkg::cmd_t      cmd
);

  msa_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.pass ? msa_pkg::ST_OUTPUT : msa_pkg::ST_UPDATE;
        end
      end
      msa_pkg::ST_UPDATE: state_nxt = msa_pkg::ST_START;
      msa_pkg::ST_START:  state_nxt = msa_pkg::ST_DIVIDE;
      msa_pkg::ST_DIVIDE: begin
        if (!sts.div_busy) begin
          state_nxt = msa_pkg::ST_OUTPUT;
        end
      end
      msa_pkg::ST_OUTPUT: begin
        if (sts.out_free) begin
          state_nxt = msa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      msa_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      msa_pkg::ST_UPDATE: cmd.update    = 1'b1;
      msa_pkg::ST_START:  cmd.div_start = 1'b1;
      msa_pkg::ST_DIVIDE: cmd           = '0;
      msa_pkg::ST_OUTPUT: cmd.load_out  = sts.out_free;
      default:            cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/msa_dp.sv
// sample ring, running sum, fill count, divider and result register
`default_nettype none
module msa_dp #(
  parameter int MAX_WINDOW = msa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [msa_pkg::WIN_W-1:0]       cfg_wr_data,
  input  wire logic [msa_pkg::SAMPLE_W-1:0]    in_sample_mv,
  input  wire msa_pkg::cmd_t                   cmd,
  output msa_pkg::sts_t                        sts,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [msa_pkg::SAMPLE_W-1:0]         out_smoothed_mv,
  output logic [msa_pkg::HELD_W-1:0]           out_samples_held
);

  localparam int SW      = msa_pkg::SAMPLE_W;
  localparam int WW      = msa_pkg::WIN_W;
  localparam int HW      = msa_pkg::HELD_W;
  localparam int WIN_MAX = (1 << WW) - 1;
  localparam int EFF_MAX = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
  localparam int SUM_W   = $clog2(((1 << SW) - 1) * EFF_MAX + 1);
  localparam int POS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW      = (POS_W + 1 > WW) ? POS_W + 1 : WW;

  logic [WW-1:0]    win_r;
  logic [WW-1:0]    win_eff;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [HW-1:0]    fill_r, fill_nxt;
  logic [SW-1:0]    sample_r;
  logic             pass_r;
  logic [SW-1:0]    rd_r;
  logic [SW-1:0]    old_sample;
  logic             warm;
  logic [CW-1:0]    wp_inc;
  logic             out_valid_r;
  logic [SW-1:0]    smoothed_r;
  logic [HW-1:0]    held_r;
  logic             div_busy;
  logic [SUM_W-1:0] quotient;

  logic [SW-1:0] ring_mem [MAX_WINDOW];

  assign win_eff = (win_r > WW'(EFF_MAX)) ? WW'(EFF_MAX) : win_r;
  assign warm    = (fill_r < win_eff);
  // slots not yet written since the last clear count as zero while filling
  assign old_sample = warm ? '0 : rd_r;
  assign wp_inc     = CW'(wp_r) + CW'(1);

  always_comb begin
    sum_nxt  = sum_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (cmd.update) begin
      sum_nxt  = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
      wp_nxt   = (wp_inc >= CW'(win_eff)) ? '0 : wp_inc[POS_W-1:0];
      fill_nxt = warm ? fill_r + HW'(1) : fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      sum_r  <= '0;
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cfg_wr_en) begin
      win_r  <= cfg_wr_data;
      sum_r  <= '0;
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample_mv;
      pass_r   <= (win_eff == '0);
    end
  end

  // read the slot at the write position every cycle, write it on update
  always_ff @(posedge clk) begin
    rd_r <= ring_mem[wp_r];
    if (cmd.update) begin
      ring_mem[wp_r] <= sample_r;
    end
  end

  msa_div #(
    .DIVIDEND_W(SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(sum_r),
    .divisor (fill_r),
    .busy    (div_busy),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      smoothed_r <= pass_r ? sample_r : quotient[SW-1:0];
      held_r     <= pass_r ? '0 : fill_r;
    end
  end

  assign sts.pass     = (win_eff == '0);
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_smoothed_mv  = smoothed_r;
  assign out_samples_held = held_r;

endmodule
`default_nettype wire

FILE: rtl/core/moving_average_smoother_top.sv
// top level of the boxcar moving average smoother
//
// input channel: in_valid/in_ready with in_sample_mv, one millivolt sample
// per request. result channel: out_valid/out_ready with out_smoothed_mv
// (running sum over the window divided by samples held) and out_samples_held.
// cfg_wr_en/cfg_wr_data set the window length (0 = pass-through, values
// above MAX_WINDOW are clamped); a write clears the sum, position and fill.
// one request is processed at a time: the next request is not taken until
// the last has been loaded into the output register. a smoothed request
// passes through update, divider start, the bit-serial divider that
// produces one quotient bit per cycle, and output; a pass-through request
// goes from the input straight to output.
// the result sits in an output register, so in_ready returns while it waits.
// when the receiver stalls with a result already held, the next request
// finishes and then waits until the held result is taken.
// reset leaves the window at 0 and the ring empty; no clearing pass is
// needed since the fill count masks slots not yet written.
`default_nettype none
module moving_average_smoother_top #(
  parameter int MAX_WINDOW = msa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [msa_pkg::WIN_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [msa_pkg::SAMPLE_W-1:0]  in_sample_mv,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [msa_pkg::SAMPLE_W-1:0]       out_smoothed_mv,
  output logic [msa_pkg::HELD_W-1:0]         out_samples_held
);

  localparam int WIN_MAX = (1 << msa_pkg::WIN_W) - 1;
  localparam int EFF_MAX = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;

  msa_pkg::cmd_t cmd;
  msa_pkg::sts_t sts;

  msa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  msa_dp #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_sample_mv    (in_sample_mv),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed_mv (out_smoothed_mv),
    .out_samples_held(out_samples_held)
  );

`ifndef SYNTH
  a_ready_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.div_busy)
    else $error("input ready while divider busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_samples_held <= msa_pkg::HELD_W'(EFF_MAX))
    else $error("samples held beyond window limit");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");
`endif

endmodule
`default_nettype wire
